// ===== rtl/lru_peer_bucket_table_assert.svh =====
// Assertion macros used by the bucket table top level.
`ifndef LRU_PEER_BUCKET_TABLE_ASSERT_SVH
`define LRU_PEER_BUCKET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpbt_pkg.sv =====
// Package with the types, codes and widths of the peer bucket table.
`timescale 1ns / 1ps

package lpbt_pkg;

    localparam int BUCKET_ENTRIES_DEF = 20;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_MOVED     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_REPLACED  = 3'd6;
    localparam logic [STATUS_W-1:0] STATUS_DUMP      = 3'd7;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_KEEP,
        CELL_PREV,
        CELL_NEXT
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } entry_t;

    typedef struct packed {
        logic hit_peer;
        logic hit_new;
    } cell_match_t;

endpackage

// ===== rtl/lpbt_cell.sv =====
// One slot of the recency chain: holds an entry, matches it and shifts it.
`timescale 1ns / 1ps

module lpbt_cell
    import lpbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  entry_t            prev_entry,
    input  entry_t            next_entry,
    input  logic [ADDR_W-1:0] peer_address,
    input  logic [PORT_W-1:0] peer_port,
    input  logic [ADDR_W-1:0] new_address,
    input  logic [PORT_W-1:0] new_port,
    output entry_t            entry,
    output cell_match_t       match
);

    logic              valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PORT_W-1:0] port_reg;
    entry_t            entry_next;

    assign entry = '{valid: valid_reg, addr: addr_reg, port: port_reg};

    // An empty slot never matches, whatever its stale payload holds.
    assign match.hit_peer = valid_reg && (addr_reg == peer_address) && (port_reg == peer_port);
    assign match.hit_new  = valid_reg && (addr_reg == new_address) && (port_reg == new_port);

    always_comb
    begin
        case (cmd)
            CELL_KEEP: entry_next = entry;
            CELL_PREV: entry_next = prev_entry;
            CELL_NEXT: entry_next = next_entry;
            default:   entry_next = entry;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= entry_next.addr;
        port_reg <= entry_next.port;
    end

endmodule

// ===== rtl/lru_peer_bucket_table.sv =====
// Top level of the peer bucket table: cell chain, operation control and result register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------------
//  command | cmd_valid, cmd_stall | operation, peer_address, peer_port, new_address,
//          |                      | new_port
//  result  | res_valid, res_stall | status, entry_address, entry_port, entry_count, last
//
// Add, delete, replace and lookup need no rotation: every cell matches at once and the
// chain shifts in the same edge, so such a transaction can follow in the next cycle.
// A dump of a non-empty table stalls the command side until the chain has rotated once
// around all BUCKET_ENTRIES cells, one step a cycle while no stalled result holds it,
// and the front cell feeds the results.
// A stalled result register holds the command side and the loading steps until it drains.
// Reset clears the valid bits, the occupancy, the control state and the result valid
// at once; there is no clearing pass.
`timescale 1ns / 1ps
`include "lru_peer_bucket_table_assert.svh"

module lru_peer_bucket_table
    import lpbt_pkg::*;
#(
    parameter  int BUCKET_ENTRIES = BUCKET_ENTRIES_DEF,
    localparam int COUNT_W        = $clog2(BUCKET_ENTRIES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   peer_address,
    input  logic [PORT_W-1:0]   peer_port,
    input  logic [ADDR_W-1:0]   new_address,
    input  logic [PORT_W-1:0]   new_port,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   entry_address,
    output logic [PORT_W-1:0]   entry_port,
    output logic [COUNT_W-1:0]  entry_count,
    output logic                last
);

    localparam int CNT_W = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  occ_reg, occ_next;

    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                last_reg, last_next;
    logic                res_load;

    entry_t              cell_entry [BUCKET_ENTRIES];
    entry_t              cell_prev  [BUCKET_ENTRIES];
    entry_t              cell_after [BUCKET_ENTRIES];
    cell_match_t         cell_match [BUCKET_ENTRIES];
    cell_cmd_t           cell_cmd   [BUCKET_ENTRIES];

    logic [BUCKET_ENTRIES-1:0] hit_p, hit_n;
    logic [BUCKET_ENTRIES-1:0] at_or_after_p, at_or_after_n;
    logic [BUCKET_ENTRIES-1:0] at_or_before_p, at_or_before_n;
    logic [BUCKET_ENTRIES-1:0] valid_vec, occ_mask;
    logic                      any_p, any_n, two_drop, full;

    logic                res_free, cmd_accept, rotate, dump_step;
    logic [COUNT_W-1:0]  cnt_wide;
    entry_t              front_key, zero_entry;

    assign res_free   = !res_valid_reg || !res_stall;
    assign cmd_stall  = (state_reg != S_IDLE) || !res_free;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rotate     = (state_reg == S_DUMP);
    assign cnt_wide   = COUNT_W'(cnt_reg);
    // Silent rotation steps past the last entry need no room in the result register.
    assign dump_step  = rotate && ((cnt_wide >= occ_reg) || res_free);
    assign full       = (occ_reg == COUNT_W'(BUCKET_ENTRIES));

    assign zero_entry = '0;
    always_comb
    begin
        front_key.valid = 1'b1;
        front_key.addr  = (operation == OP_REPLACE) ? new_address : peer_address;
        front_key.port  = (operation == OP_REPLACE) ? new_port : peer_port;
    end

    // The chain: cell 0 loads the key, and cell 0 wraps to the last cell while dumping.
    genvar g;
    for (g = 0; g < BUCKET_ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_front
            assign cell_prev[g] = front_key;
        end
        else
        begin : g_inner_prev
            assign cell_prev[g] = cell_entry[g-1];
        end
        if (g == BUCKET_ENTRIES - 1)
        begin : g_tail
            assign cell_after[g] = rotate ? cell_entry[0] : zero_entry;
        end
        else
        begin : g_inner_next
            assign cell_after[g] = cell_entry[g+1];
        end

        lpbt_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cell_cmd[g]),
            .prev_entry   (cell_prev[g]),
            .next_entry   (cell_after[g]),
            .peer_address (peer_address),
            .peer_port    (peer_port),
            .new_address  (new_address),
            .new_port     (new_port),
            .entry        (cell_entry[g]),
            .match        (cell_match[g])
        );

        assign hit_p[g]     = cell_match[g].hit_peer;
        assign hit_n[g]     = cell_match[g].hit_new;
        assign valid_vec[g] = cell_entry[g].valid;
        assign occ_mask[g]  = (COUNT_W'(g) < occ_reg);
    end

    always_comb
    begin
        for (int i = 0; i < BUCKET_ENTRIES; i++)
        begin
            at_or_after_p[i]  = |(hit_p >> i);
            at_or_after_n[i]  = |(hit_n >> i);
            at_or_before_p[i] = |(hit_p << (BUCKET_ENTRIES - 1 - i));
            at_or_before_n[i] = |(hit_n << (BUCKET_ENTRIES - 1 - i));
        end
    end

    assign any_p    = |hit_p;
    assign any_n    = |hit_n;
    // Replace removes two distinct entries when the new one already sits elsewhere.
    assign two_drop = any_p && any_n && (hit_p != hit_n);

    // Per-cell shift commands.
    always_comb
    begin
        for (int i = 0; i < BUCKET_ENTRIES; i++)
        begin
            cell_cmd[i] = CELL_KEEP;
            if (cmd_accept)
            begin
                case (operation)
                    OP_ADD:
                    begin
                        if (any_p)
                        begin
                            cell_cmd[i] = at_or_after_p[i] ? CELL_PREV : CELL_KEEP;
                        end
                        else if (!full)
                        begin
                            cell_cmd[i] = CELL_PREV;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (any_p && at_or_before_p[i])
                        begin
                            cell_cmd[i] = CELL_NEXT;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (two_drop)
                        begin
                            if (at_or_after_p[i] && at_or_after_n[i])
                            begin
                                cell_cmd[i] = CELL_PREV;
                            end
                            else if (at_or_before_p[i] && at_or_before_n[i])
                            begin
                                cell_cmd[i] = CELL_NEXT;
                            end
                        end
                        else if (any_p && at_or_after_p[i])
                        begin
                            cell_cmd[i] = CELL_PREV;
                        end
                    end
                    default:
                    begin
                        cell_cmd[i] = CELL_KEEP;
                    end
                endcase
            end
            else if (dump_step)
            begin
                cell_cmd[i] = CELL_NEXT;
            end
        end
    end

    // Occupancy, control state and the result to load.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        occ_next    = occ_reg;
        res_load    = 1'b0;
        status_next = STATUS_NOT_FOUND;
        addr_next   = '0;
        port_next   = '0;
        last_next   = 1'b1;

        if (cmd_accept)
        begin
            res_load = 1'b1;
            case (operation)
                OP_ADD:
                begin
                    if (any_p)
                    begin
                        status_next = STATUS_MOVED;
                    end
                    else if (!full)
                    begin
                        status_next = STATUS_INSERTED;
                        occ_next    = occ_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                        addr_next   = cell_entry[BUCKET_ENTRIES-1].addr;
                        port_next   = cell_entry[BUCKET_ENTRIES-1].port;
                    end
                end
                OP_DELETE:
                begin
                    if (any_p)
                    begin
                        status_next = STATUS_REMOVED;
                        occ_next    = occ_reg - COUNT_W'(1);
                    end
                end
                OP_REPLACE:
                begin
                    if (any_p)
                    begin
                        status_next = STATUS_REPLACED;
                        if (two_drop)
                        begin
                            occ_next = occ_reg - COUNT_W'(1);
                        end
                    end
                end
                OP_LOOKUP:
                begin
                    status_next = any_p ? STATUS_FOUND : STATUS_NOT_FOUND;
                end
                OP_DUMP:
                begin
                    if (occ_reg != '0)
                    begin
                        res_load   = 1'b0;
                        state_next = S_DUMP;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            endcase
        end
        else if (dump_step)
        begin
            res_load    = (cnt_wide < occ_reg);
            status_next = STATUS_DUMP;
            addr_next   = cell_entry[0].addr;
            port_next   = cell_entry[0].port;
            last_next   = ((cnt_wide + COUNT_W'(1)) == occ_reg);
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(BUCKET_ENTRIES - 1))
            begin
                state_next = S_IDLE;
            end
        end

        count_next = occ_next;

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            port_reg   <= port_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign entry_address = addr_reg;
    assign entry_port    = port_reg;
    assign entry_count   = count_reg;
    assign last          = last_reg;

    `LPBT_ASSERT_SAME(a_valid_matches_occ, state_reg == S_IDLE, valid_vec == occ_mask, "valid bits do not match occupancy")
    `LPBT_ASSERT_SAME(a_occ_in_range, 1'b1, occ_reg <= COUNT_W'(BUCKET_ENTRIES), "occupancy exceeds table size")
    `LPBT_ASSERT_NEXT(a_occ_stable_dump, state_reg == S_DUMP, $stable(occ_reg), "occupancy changed during dump")
    `LPBT_ASSERT_NEXT(a_single_result, cmd_accept && ((operation != OP_DUMP) || (occ_reg == '0)), res_valid_reg && last_reg, "single result not loaded")

endmodule

// ===== dv/lru_peer_bucket_table_tb.sv =====
// Testbench for the peer bucket table: random and directed commands checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import lpbt_pkg::*;

    localparam int TABLE_DEPTH     = BUCKET_ENTRIES_DEF;
    localparam int COUNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int POOL_SIZE       = 28;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [PORT_W-1:0]   port;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } bucket_result_t;

    class bucket_scoreboard;
        // Predicted table contents, most recent entry first.
        logic [ADDR_W-1:0] held_addr[$];
        logic [PORT_W-1:0] held_port[$];
        bucket_result_t    awaited_results[$];
        int                failures = 0;

        function int slot_of_peer(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
            foreach (held_addr[i])
                if (held_addr[i] == a && held_port[i] == p)
                    return i;
            return -1;
        endfunction

        function void drop_slot(input int s);
            held_addr.delete(s);
            held_port.delete(s);
        endfunction

        function void put_front(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
            held_addr.insert(0, a);
            held_port.insert(0, p);
        endfunction

        function void queue_result(input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] a,
                                   input logic [PORT_W-1:0] p, input logic lst);
            bucket_result_t r;
            r.status = st;
            r.addr   = a;
            r.port   = p;
            r.count  = COUNT_W'(held_addr.size());
            r.last   = lst;
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        function void apply_command(input logic [OP_W-1:0] op,
                                    input logic [ADDR_W-1:0] pa, input logic [PORT_W-1:0] pp,
                                    input logic [ADDR_W-1:0] na, input logic [PORT_W-1:0] np);
            int s;
            s = slot_of_peer(pa, pp);
            case (op)
                OP_ADD:
                    if (s >= 0)
                    begin
                        drop_slot(s);
                        put_front(pa, pp);
                        queue_result(STATUS_MOVED, '0, '0, 1'b1);
                    end
                    else if (held_addr.size() < TABLE_DEPTH)
                    begin
                        put_front(pa, pp);
                        queue_result(STATUS_INSERTED, '0, '0, 1'b1);
                    end
                    else
                        queue_result(STATUS_FULL, held_addr[TABLE_DEPTH - 1],
                                     held_port[TABLE_DEPTH - 1], 1'b1);
                OP_DELETE:
                    if (s >= 0)
                    begin
                        drop_slot(s);
                        queue_result(STATUS_REMOVED, '0, '0, 1'b1);
                    end
                    else
                        queue_result(STATUS_NOT_FOUND, '0, '0, 1'b1);
                OP_REPLACE:
                    if (s >= 0)
                    begin
                        // A copy of the new entry elsewhere is dropped so entries stay unique.
                        drop_slot(s);
                        s = slot_of_peer(na, np);
                        if (s >= 0)
                            drop_slot(s);
                        put_front(na, np);
                        queue_result(STATUS_REPLACED, '0, '0, 1'b1);
                    end
                    else
                        queue_result(STATUS_NOT_FOUND, '0, '0, 1'b1);
                OP_LOOKUP:
                    queue_result((s >= 0) ? STATUS_FOUND : STATUS_NOT_FOUND, '0, '0, 1'b1);
                OP_DUMP:
                    if (held_addr.size() == 0)
                        queue_result(STATUS_NOT_FOUND, '0, '0, 1'b1);
                    else
                        foreach (held_addr[i])
                            queue_result(STATUS_DUMP, held_addr[i], held_port[i],
                                         i == held_addr.size() - 1);
                default:
                    queue_result(STATUS_NOT_FOUND, '0, '0, 1'b1);
            endcase
        endfunction

        function void compare_field(input string field, input logic [ADDR_W-1:0] want,
                                    input logic [ADDR_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(input bucket_result_t got);
            bucket_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("Result transaction with none awaited: status %0d", got.status);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("entry_address", want.addr, got.addr);
            compare_field("entry_port", want.port, got.port);
            compare_field("entry_count", want.count, got.count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [OP_W-1:0]     operation = OP_ADD;
    logic [ADDR_W-1:0]   peer_address = '0;
    logic [PORT_W-1:0]   peer_port = '0;
    logic [ADDR_W-1:0]   new_address = '0;
    logic [PORT_W-1:0]   new_port = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   entry_address;
    logic [PORT_W-1:0]   entry_port;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
    logic [PORT_W-1:0] pool_port[POOL_SIZE];

    bucket_scoreboard scoreboard = new;

    lru_peer_bucket_table #(
        .BUCKET_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .operation(operation),
        .peer_address(peer_address),
        .peer_port(peer_port),
        .new_address(new_address),
        .new_port(new_port),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .entry_address(entry_address),
        .entry_port(entry_port),
        .entry_count(entry_count),
        .last(last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [PORT_W-1:0] rand_port();
        return PORT_W'($urandom_range(65535));
    endfunction

    // Offers one command after a random gap and returns at the edge that accepts it.
    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic [ADDR_W-1:0] pa, input logic [PORT_W-1:0] pp,
                                input logic [ADDR_W-1:0] na, input logic [PORT_W-1:0] np);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        operation    <= op;
        peer_address <= pa;
        peer_port    <= pp;
        new_address  <= na;
        new_port     <= np;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // When the table should hold peers, half the time one of them, otherwise one from the pool.
    task automatic pick_target(output logic [ADDR_W-1:0] a, output logic [PORT_W-1:0] p);
        int n;
        n = scoreboard.held_addr.size();
        if (n > 0 && $urandom_range(1) == 1)
        begin
            n = $urandom_range(n - 1);
            a = scoreboard.held_addr[n];
            p = scoreboard.held_port[n];
        end
        else
        begin
            n = $urandom_range(POOL_SIZE - 1);
            a = pool_addr[n];
            p = pool_port[n];
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bucket_result_t got;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                scoreboard.apply_command(operation, peer_address, peer_port,
                                         new_address, new_port);
            if (res_valid && !res_stall)
            begin
                got.status = status;
                got.addr   = entry_address;
                got.port   = entry_port;
                got.count  = entry_count;
                got.last   = last;
                scoreboard.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] max_addr;
        logic [PORT_W-1:0] max_port;
        logic [ADDR_W-1:0] ta;
        logic [PORT_W-1:0] tp;
        logic [ADDR_W-1:0] ra;
        logic [PORT_W-1:0] rp;
        int                roll;
        int                other;

        max_addr = '1;
        max_port = '1;
        // Odd pool members share the address of their neighbor, so only the port differs.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_addr[i] = (i % 2 == 1) ? pool_addr[i - 1] : $urandom;
            pool_port[i] = rand_port();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 38 : 0;
            if (phase == 0)
            begin
                send_command(OP_DUMP, '0, '0, '0, '0);
                send_command(OP_RESERVED_FIRST, $urandom, rand_port(),
                             $urandom, rand_port());
                send_command(OP_ADD, '0, '0, '0, '0);
                send_command(OP_ADD, max_addr, max_port, max_addr, max_port);
                send_command(OP_ADD, max_addr, '0, '0, '0);
                send_command(OP_LOOKUP, max_addr, '0, '0, '0);
                send_command(OP_LOOKUP, '0, max_port, '0, '0);
                send_command(OP_ADD, '0, '0, '0, '0);
                send_command(OP_DELETE, max_addr, max_port, '0, '0);
                send_command(OP_DELETE, max_addr, max_port, '0, '0);
                send_command(OP_REPLACE, max_addr, max_port, '0, '0);
                send_command(OP_REPLACE, max_addr, '0, max_addr, '0);
                send_command(OP_REPLACE, '0, '0, max_addr, '0);
                send_command(OP_RESERVED_LAST, $urandom, rand_port(),
                             $urandom, rand_port());
                // Fill the table past its capacity, then dump it while the receiver holds off.
                for (int i = 0; i <= TABLE_DEPTH; i++)
                    send_command(OP_ADD, pool_addr[i], pool_port[i], $urandom,
                                 rand_port());
                hold_off_req = 1'b1;
                send_command(OP_DUMP, $urandom, rand_port(), $urandom,
                             rand_port());
            end
            repeat (RANDOM_PER_PHASE)
            begin
                roll  = $urandom_range(99);
                other = $urandom_range(POOL_SIZE - 1);
                ra    = $urandom;
                rp    = rand_port();
                if (roll < 38)
                    send_command(OP_ADD, pool_addr[other], pool_port[other], ra, rp);
                else if (roll < 52)
                begin
                    pick_target(ta, tp);
                    send_command(OP_DELETE, ta, tp, ra, rp);
                end
                else if (roll < 66)
                begin
                    pick_target(ta, tp);
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5:
                            send_command(OP_REPLACE, ta, tp, pool_addr[other], pool_port[other]);
                        6, 7:
                            send_command(OP_REPLACE, ta, tp, ra, rp);
                        default:
                            send_command(OP_REPLACE, ta, tp, ta, tp);
                    endcase
                end
                else if (roll < 80)
                begin
                    pick_target(ta, tp);
                    send_command(OP_LOOKUP, ta, tp, ra, rp);
                end
                else if (roll < 88)
                    send_command(OP_DUMP, ra, rp, $urandom, rand_port());
                else if (roll < 94)
                    send_command(OP_W'($urandom_range(7)), ra, rp, $urandom, rand_port());
                else
                    send_command(OP_ADD, ra, rp, $urandom, rand_port());
            end
        end
        cmd_valid <= 1'b0;

        while (scoreboard.awaited_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 4) @(posedge clk);

        if (scoreboard.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
